// ===== src/assert_macros.svh =====
// Assertion macros shared by the predictor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SWMP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition at one edge implies the expression at the following edge.
`define SWMP_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/swmp_pkg.sv =====
// Shared types, codes and helpers of the sliding window majority predictor.
`default_nettype none

package swmp_pkg;

    localparam int unsigned WINDOW_MAX_DEF = 128;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned ACTION_W   = 8;
    localparam int unsigned GUESS_W    = 2;
    localparam int unsigned TALLY_W    = 8;

    localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 8'd99;

    localparam logic [ACTION_W-1:0] CHAR_INS_UC = 8'h49;
    localparam logic [ACTION_W-1:0] CHAR_INS_LC = 8'h69;
    localparam logic [ACTION_W-1:0] CHAR_UPD_UC = 8'h55;
    localparam logic [ACTION_W-1:0] CHAR_UPD_LC = 8'h75;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GUESS_MODE  = 1'b0,
        CFG_WINDOW_SIZE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_MAJORITY = 2'd0,
        MODE_INSERT   = 2'd1,
        MODE_UPDATE   = 2'd2,
        MODE_SELECT   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_UPDATE = 2'd2
    } t_act;

    typedef enum logic [GUESS_W-1:0] {
        GUESS_INSERT = 2'd0,
        GUESS_UPDATE = 2'd1,
        GUESS_SELECT = 2'd2
    } t_guess;

    function automatic t_act decode_action(input logic [ACTION_W-1:0] b);
        t_act a;
        if (b == CHAR_INS_UC || b == CHAR_INS_LC) begin
            a = ACT_INSERT;
        end else if (b == CHAR_UPD_UC || b == CHAR_UPD_LC) begin
            a = ACT_UPDATE;
        end else begin
            a = ACT_NONE;
        end
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== src/swmp_in_if.sv =====
// Input channel: one observed action byte per transaction.
`default_nettype none

interface swmp_in_if;
    logic                          valid;
    logic                          ready;
    logic [swmp_pkg::ACTION_W-1:0] action_byte;

    modport source (output valid, output action_byte, input ready);
    modport sink   (input valid, input action_byte, output ready);
endinterface

`default_nettype wire

// ===== src/swmp_out_if.sv =====
// Output channel: guess and window tallies, one per transaction.
`default_nettype none

interface swmp_out_if;
    logic                         valid;
    logic                         ready;
    logic [swmp_pkg::GUESS_W-1:0] guess;
    logic [swmp_pkg::TALLY_W-1:0] insert_tally;
    logic [swmp_pkg::TALLY_W-1:0] update_tally;

    modport source (output valid, output guess, output insert_tally, output update_tally,
                    input ready);
    modport sink   (input valid, input guess, input insert_tally, input update_tally,
                    output ready);
endinterface

`default_nettype wire

// ===== src/sliding_window_majority_predictor_core.sv =====
// Sliding window majority predictor: takes one action byte per transaction and returns
// the guess made before it plus the insert and update counts of the last N actions.
// Throughput is one transaction per clock while the result is not stalled. An accepted
// transaction waits in the input register and is processed into the result register once
// that register is empty or being read; a stalled result holds the input register and,
// through ready, the input side. The history ring is a register array with one read and
// one write per cycle, the read one entry ahead of the ring pointer. Reset and a
// window_size write clear the history at once: entries not written since the clear read
// as none, which the ring pointer and a wrap flag track, so no clearing pass is needed.
`default_nettype none

module sliding_window_majority_predictor_core #(
    parameter int unsigned WINDOW_MAX = swmp_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [swmp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [swmp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    swmp_in_if.sink                              i_in,
    swmp_out_if.source                           o_out
);
    import swmp_pkg::*;

`include "assert_macros.svh"

    localparam int unsigned PTR_W = $clog2(WINDOW_MAX);
    localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int unsigned CMP_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [CMP_W-1:0] WIN_MAX_C = CMP_W'(WINDOW_MAX);
    localparam logic [CMP_W-1:0] TALLY_MAX = CMP_W'(255);

    // configuration
    t_mode                 r_mode;
    logic [CFG_DATA_W-1:0] r_win;

    // input register
    logic                r_in_valid;
    logic [ACTION_W-1:0] r_in_byte;

    // window state
    logic [PTR_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_ins_cnt;
    logic [CNT_W-1:0]      r_upd_cnt;
    logic                  r_wrapped;
    t_act                  r_mem [WINDOW_MAX];
    t_act                  r_rd_data;
    logic                  r_rd_vld;

    // result register
    logic               r_out_valid;
    t_guess             r_out_guess;
    logic [TALLY_W-1:0] r_out_ins;
    logic [TALLY_W-1:0] r_out_upd;

    logic             win_clear;
    logic             advance;
    logic             in_acc;
    logic [CMP_W-1:0] win_ext;
    logic [CNT_W-1:0] eff_win;
    logic [CNT_W-1:0] pos_inc;
    logic [PTR_W-1:0] next_pos;
    logic [PTR_W-1:0] rd_addr;
    logic             fwd;
    t_act             act;
    t_act             old_act;
    t_guess           guess;
    logic [CNT_W-1:0] n_ins_cnt;
    logic [CNT_W-1:0] n_upd_cnt;
    logic [CMP_W-1:0] ins_ext;
    logic [CMP_W-1:0] upd_ext;
    logic [TALLY_W-1:0] n_out_ins;
    logic [TALLY_W-1:0] n_out_upd;

    assign win_clear = i_cfg_we && (i_cfg_idx == CFG_WINDOW_SIZE);
    assign advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_acc    = i_in.valid && i_in.ready;

    // zero or an oversize value selects the largest window
    always_comb begin
        win_ext = CMP_W'(r_win);
        if (win_ext == '0 || win_ext > WIN_MAX_C) begin
            eff_win = CNT_W'(WIN_MAX_C);
        end else begin
            eff_win = CNT_W'(win_ext);
        end
    end

    assign pos_inc  = CNT_W'(r_pos) + CNT_W'(1);
    assign next_pos = (pos_inc >= eff_win) ? '0 : pos_inc[PTR_W-1:0];
    assign rd_addr  = advance ? next_pos : r_pos;
    // a one-entry window rereads the slot written this cycle
    assign fwd      = advance && (next_pos == r_pos);

    assign act     = decode_action(r_in_byte);
    assign old_act = r_rd_vld ? r_rd_data : ACT_NONE;

    always_comb begin
        case (r_mode)
            MODE_MAJORITY: guess = (r_ins_cnt > r_upd_cnt) ? GUESS_INSERT : GUESS_UPDATE;
            MODE_INSERT:   guess = GUESS_INSERT;
            MODE_UPDATE:   guess = GUESS_UPDATE;
            MODE_SELECT:   guess = GUESS_SELECT;
            default:       guess = GUESS_SELECT;
        endcase
    end

    assign n_ins_cnt = r_ins_cnt - CNT_W'(old_act == ACT_INSERT) + CNT_W'(act == ACT_INSERT);
    assign n_upd_cnt = r_upd_cnt - CNT_W'(old_act == ACT_UPDATE) + CNT_W'(act == ACT_UPDATE);

    assign ins_ext   = CMP_W'(n_ins_cnt);
    assign upd_ext   = CMP_W'(n_upd_cnt);
    assign n_out_ins = (ins_ext > TALLY_MAX) ? '1 : ins_ext[TALLY_W-1:0];
    assign n_out_upd = (upd_ext > TALLY_MAX) ? '1 : upd_ext[TALLY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_MAJORITY;
            r_win       <= WINDOW_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_ins_cnt   <= '0;
            r_upd_cnt   <= '0;
            r_wrapped   <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_GUESS_MODE) begin
                r_mode <= t_mode'(i_cfg_data[1:0]);
            end
            if (win_clear) begin
                r_win <= i_cfg_data;
            end

            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (win_clear) begin
                r_pos     <= '0;
                r_ins_cnt <= '0;
                r_upd_cnt <= '0;
                r_wrapped <= 1'b0;
                r_rd_vld  <= 1'b0;
            end else if (advance) begin
                r_pos     <= next_pos;
                r_ins_cnt <= n_ins_cnt;
                r_upd_cnt <= n_upd_cnt;
                // before the first wrap only slots behind the pointer hold actions
                r_wrapped <= r_wrapped || (next_pos == '0);
                r_rd_vld  <= r_wrapped || (next_pos == '0);
            end else begin
                r_rd_vld <= r_wrapped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in.action_byte;
        end
        if (advance) begin
            r_mem[r_pos] <= act;
            r_out_guess  <= guess;
            r_out_ins    <= n_out_ins;
            r_out_upd    <= n_out_upd;
        end
        r_rd_data <= fwd ? act : r_mem[rd_addr];
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.guess        = r_out_guess;
    assign o_out.insert_tally = r_out_ins;
    assign o_out.update_tally = r_out_upd;

    `SWMP_ASSERT_CLK(a_pos_in_window, i_clk, i_rst_n,
        CNT_W'(r_pos) < eff_win, "ring pointer outside window")
    `SWMP_ASSERT_CLK(a_tallies_fit, i_clk, i_rst_n,
        SUM_W'(r_ins_cnt) + SUM_W'(r_upd_cnt) <= SUM_W'(eff_win), "tallies exceed window")
    `SWMP_ASSERT_NEXT(a_win_clear, i_clk, i_rst_n, i_rst_n && win_clear,
        r_ins_cnt == '0 && r_upd_cnt == '0 && r_pos == '0 && !r_rd_vld,
        "window write did not clear history")
    `SWMP_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, i_rst_n && advance,
        r_out_valid, "processed transaction produced no result")

endmodule

`default_nettype wire
